### src/pru_pkg.sv
package pru_pkg;

	localparam int DT_W    = 16;
	localparam int POS_W   = 24;
	localparam int PROG_W  = 17;
	localparam int SLOT_W  = 6;
	localparam int ADDR_W  = 6;

	localparam logic [16:0] PROGRESS_ONE = 17'h10000;
	localparam logic [15:0] LFSR_SEED    = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS    = 16'hB400;
	localparam logic [23:0] SPAWN_Z_POS  = 24'd25600;
	localparam logic [6:0]  SPAWN_RANGE  = 7'd100;

	localparam logic [3:0] REG_TIMING     = 4'd0;
	localparam logic [3:0] REG_GRAVITY    = 4'd1;
	localparam logic [3:0] REG_SIZE       = 4'd2;
	localparam logic [3:0] REG_START_COL  = 4'd3;
	localparam logic [3:0] REG_END_COL    = 4'd4;
	localparam logic [3:0] REG_START_VEL  = 4'd5;
	localparam logic [3:0] REG_END_VEL    = 4'd6;
	localparam logic [3:0] REG_COUNT      = 4'd7;

	// shared multiplier operation
	typedef enum logic [1:0] {
		MOP_LERP   = 2'd0,
		MOP_DTMUL  = 2'd1
	} mop_t;

	typedef struct packed {
		logic [31:0] timing;
		logic [15:0] gravity;
		logic [31:0] size_range;
		logic [63:0] start_color;
		logic [63:0] end_color;
		logic [47:0] start_vel;
		logic [47:0] end_vel;
		logic [6:0]  count;
	} cfg_t;

	typedef struct packed {
		logic [5:0]  slot_index;
		logic [23:0] pos_x;
		logic [23:0] pos_y;
		logic [23:0] pos_z;
		logic [15:0] color_r;
		logic [15:0] color_g;
		logic [15:0] color_b;
		logic [15:0] color_a;
		logic [15:0] size;
		logic [15:0] age;
		logic        last;
	} result_t;

	// floor shift of a signed product, saturating add into a signed width
	function automatic logic [23:0] sat_add24(input logic signed [23:0] a,
		input logic signed [40:0] prod);
		logic signed [28:0] d;
		logic signed [29:0] s;
		begin
			d = 29'(prod >>> 12);
			s = 30'(a) + 30'(d);
			if (s > 30'sd8388607)
				sat_add24 = 24'h7FFFFF;
			else if (s < -30'sd8388608)
				sat_add24 = 24'h800000;
			else
				sat_add24 = s[23:0];
		end
	endfunction

endpackage

### src/pru_if.sv
interface pru_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] delta_time;
	modport source (output valid, output delta_time, input ready);
	modport sink (input valid, input delta_time, output ready);
endinterface

interface pru_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  slot_index;
	logic [23:0] pos_x;
	logic [23:0] pos_y;
	logic [23:0] pos_z;
	logic [15:0] color_r;
	logic [15:0] color_g;
	logic [15:0] color_b;
	logic [15:0] color_a;
	logic [15:0] size;
	logic [15:0] age;
	logic        last;
	modport source (output valid, output slot_index, output pos_x, output pos_y,
		output pos_z, output color_r, output color_g, output color_b, output color_a,
		output size, output age, output last, input ready);
	modport sink (input valid, input slot_index, input pos_x, input pos_y,
		input pos_z, input color_r, input color_g, input color_b, input color_a,
		input size, input age, input last, output ready);
endinterface

### src/pru_regs.sv
module pru_regs
	import pru_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);
	cfg_t cfg_q;
	logic [3:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx = {1'b0, paddr[5:3]};
	assign wr = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timing <= 32'd4096;
			cfg_q.gravity <= '0;
			cfg_q.size_range <= 32'd256;
			cfg_q.start_color <= '0;
			cfg_q.end_color <= '0;
			cfg_q.start_vel <= '0;
			cfg_q.end_vel <= '0;
			cfg_q.count <= 7'd64;
		end else if (wr && paddr[2:0] == 3'd0) begin
			case (idx)
				REG_TIMING:    cfg_q.timing <= pwdata[31:0];
				REG_GRAVITY:   cfg_q.gravity <= pwdata[15:0];
				REG_SIZE:      cfg_q.size_range <= pwdata[31:0];
				REG_START_COL: cfg_q.start_color <= pwdata;
				REG_END_COL:   cfg_q.end_color <= pwdata;
				REG_START_VEL: cfg_q.start_vel <= pwdata[47:0];
				REG_END_VEL:   cfg_q.end_vel <= pwdata[47:0];
				REG_COUNT:     cfg_q.count <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TIMING:    prdata = {32'd0, cfg_q.timing};
			REG_GRAVITY:   prdata = {48'd0, cfg_q.gravity};
			REG_SIZE:      prdata = {32'd0, cfg_q.size_range};
			REG_START_COL: prdata = cfg_q.start_color;
			REG_END_COL:   prdata = cfg_q.end_color;
			REG_START_VEL: prdata = {16'd0, cfg_q.start_vel};
			REG_END_VEL:   prdata = {16'd0, cfg_q.end_vel};
			REG_COUNT:     prdata = {57'd0, cfg_q.count};
			default:       prdata = '0;
		endcase
	end
endmodule

### src/pru_mul.sv
module pru_mul
	import pru_pkg::*;
(
	input  logic               clk,
	input  mop_t               op,
	input  logic signed [16:0] a,
	input  logic signed [16:0] b,
	input  logic        [16:0] p,
	input  logic        [15:0] dt,
	output logic signed [40:0] prod_q
);
	logic signed [17:0] diff;
	logic signed [40:0] prod;

	always_comb begin
		diff = 18'(b) - 18'(a);
		case (op)
			MOP_LERP:  prod = 41'(diff * $signed({1'b0, p}));
			MOP_DTMUL: prod = 41'(a * $signed({1'b0, dt}));
			default:   prod = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= prod;
	end
endmodule

### src/particle_ring_update_core.sv
// Particle ring updater. Each accepted delta_time word is one tick: the spawn
// timer advances, maybe one slot is re-spawned, then every slot in use
// (particle_count, clamped to 1..MAX_PARTICLES) is advanced and streamed out
// in slot order with last on the final slot. One shared multiplier does all lerps
// (18x18) and dt products (17x17), one per cycle, so a slot passes through read,
// the multiply steps, write back and hand-off, plus output wait, and a tick adds
// a spawn state when it spawns. Reset clears the slot store, during which no
// tick is accepted.
module particle_ring_update_core
	import pru_pkg::*;
#(
	parameter int MAX_PARTICLES = 64
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	pru_in_if.sink      in_ch,
	pru_out_if.source   out_ch
);
	localparam int MW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_SPAWN = 7'b0000100,
		ST_READ  = 7'b0001000,
		ST_CALC  = 7'b0010000,
		ST_WRITE = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	cfg_t cfg;
	state_t state_q;
	logic [MW-1:0] slot_q, cnt_m1_q, ring_q;
	logic [MW:0]   clr_q;
	logic [15:0] dt_q, timer_q, lfsr_q;
	logic [3:0]  step_q;

	logic [23:0] px_mem [MAX_PARTICLES];
	logic [23:0] py_mem [MAX_PARTICLES];
	logic [23:0] pz_mem [MAX_PARTICLES];
	logic [15:0] vy_mem [MAX_PARTICLES];
	logic [16:0] pg_mem [MAX_PARTICLES];
	logic [15:0] ag_mem [MAX_PARTICLES];

	logic [23:0] px_q, py_q, pz_q;
	logic [15:0] vy_q, ag_q, vx_q, vz_q;
	logic [16:0] pg_q;
	result_t res_q;
	result_t out_q;
	logic out_v_q;

	mop_t op;
	logic signed [16:0] ma, mb;
	logic signed [40:0] prod_q;

	pru_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);

	pru_mul u_mul (.clk, .op, .a(ma), .b(mb), .p(pg_q), .dt(dt_q), .prod_q);

	logic [6:0] cnt_c;
	always_comb begin
		if (cfg.count == 7'd0)
			cnt_c = 7'd1;
		else if (cfg.count > 7'(MAX_PARTICLES))
			cnt_c = 7'(MAX_PARTICLES);
		else
			cnt_c = cfg.count;
	end

	logic [16:0] tsum;
	logic [15:0] tsat, lfsr_n;
	logic [6:0] lmod;
	logic [MW-1:0] ring_use;
	logic [16:0] rate_add, pg_new;
	logic [16:0] asum;
	assign tsum = 17'(timer_q) + 17'(in_ch.delta_time);
	assign tsat = tsum[16] ? 16'hFFFF : tsum[15:0];
	assign lfsr_n = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
	// mod 100 via reciprocal: q = (v*655)>>16, then at most one correction
	logic [25:0] recip;
	logic [9:0]  qv;
	logic [16:0] remv;
	assign recip = 26'(lfsr_n) * 26'd655;
	assign qv = recip[25:16];
	assign remv = 17'(lfsr_n) - 17'(qv) * 17'(SPAWN_RANGE);
	assign lmod = (remv >= 17'(SPAWN_RANGE)) ? 7'(remv - 17'(SPAWN_RANGE)) : 7'(remv);
	assign ring_use = (7'(ring_q) >= cnt_c) ? '0 : ring_q;

	always_comb begin
		logic [31:0] rp;
		rp = 32'(cfg.timing[15:0]) * 32'(dt_q);
		rate_add = 17'(rp >> 8);
		if (rp[31:25] != '0) rate_add = PROGRESS_ONE;
		asum = 17'(ag_q) + 17'(dt_q);
	end
	assign pg_new = (18'(pg_q) + 18'(rate_add) > 18'(PROGRESS_ONE)) ? PROGRESS_ONE
		: 17'(pg_q + rate_add);

	// operand selection per step
	always_comb begin
		op = MOP_LERP;
		ma = '0;
		mb = '0;
		case (step_q)
			4'd0: begin ma = 17'($signed(cfg.start_vel[47:32])); mb = 17'($signed(cfg.end_vel[47:32])); end
			4'd1: begin ma = 17'($signed(cfg.start_vel[15:0])); mb = 17'($signed(cfg.end_vel[15:0])); end
			4'd2: begin
				if (cfg.gravity == '0) begin
					ma = 17'($signed(cfg.start_vel[31:16])); mb = 17'($signed(cfg.end_vel[31:16]));
				end else begin
					op = MOP_DTMUL; ma = 17'($signed(cfg.gravity));
				end
			end
			4'd3: begin op = MOP_DTMUL; ma = 17'($signed(vx_q)); end
			4'd4: begin op = MOP_DTMUL; ma = 17'($signed(vy_q)); end
			4'd5: begin op = MOP_DTMUL; ma = 17'($signed(vz_q)); end
			4'd6: begin ma = {1'b0, cfg.start_color[63:48]}; mb = {1'b0, cfg.end_color[63:48]}; end
			4'd7: begin ma = {1'b0, cfg.start_color[47:32]}; mb = {1'b0, cfg.end_color[47:32]}; end
			4'd8: begin ma = {1'b0, cfg.start_color[31:16]}; mb = {1'b0, cfg.end_color[31:16]}; end
			4'd9: begin ma = {1'b0, cfg.start_color[15:0]}; mb = {1'b0, cfg.end_color[15:0]}; end
			4'd10: begin ma = {1'b0, cfg.size_range[31:16]}; mb = {1'b0, cfg.size_range[15:0]}; end
			default: ;
		endcase
	end

	// previous step's operand for lerp result: ma held registered
	logic signed [16:0] ma_q;
	logic [3:0] pstep_q;
	logic [16:0] lerp_p;
	logic signed [29:0] gsum;
	assign lerp_p = 17'(ma_q) + 17'(prod_q >>> 16);
	assign gsum = 30'($signed(vy_q)) - 30'(prod_q >>> 12);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.slot_index = out_q.slot_index;
	assign out_ch.pos_x = out_q.pos_x;
	assign out_ch.pos_y = out_q.pos_y;
	assign out_ch.pos_z = out_q.pos_z;
	assign out_ch.color_r = out_q.color_r;
	assign out_ch.color_g = out_q.color_g;
	assign out_ch.color_b = out_q.color_b;
	assign out_ch.color_a = out_q.color_a;
	assign out_ch.size = out_q.size;
	assign out_ch.age = out_q.age;
	assign out_ch.last = out_q.last;

	logic mem_we;
	logic [MW-1:0] mem_wa;
	logic [23:0] wpx, wpy, wpz;
	logic [15:0] wvy, wag;
	logic [16:0] wpg;
	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot_q;
		wpx = px_q; wpy = py_q; wpz = pz_q; wvy = vy_q; wpg = pg_q; wag = ag_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1; mem_wa = clr_q[MW-1:0];
				wpx = '0; wpy = '0; wpz = '0; wvy = '0; wpg = '0; wag = '0;
			end
			ST_SPAWN: begin
				mem_we = 1'b1; mem_wa = ring_use;
				wpx = {9'd0, lmod, 8'd0}; wpy = '0; wpz = SPAWN_Z_POS;
				wvy = cfg.start_vel[31:16]; wpg = '0; wag = '0;
			end
			ST_WRITE: mem_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			px_mem[mem_wa] <= wpx; py_mem[mem_wa] <= wpy; pz_mem[mem_wa] <= wpz;
			vy_mem[mem_wa] <= wvy; pg_mem[mem_wa] <= wpg; ag_mem[mem_wa] <= wag;
		end
	end

	always_ff @(posedge clk) begin
		ma_q <= ma;
		pstep_q <= step_q;
		if (state_q == ST_READ) begin
			px_q <= px_mem[slot_q]; py_q <= py_mem[slot_q]; pz_q <= pz_mem[slot_q];
			vy_q <= vy_mem[slot_q]; pg_q <= pg_mem[slot_q]; ag_q <= ag_mem[slot_q];
			step_q <= 4'd15;
		end else if (state_q == ST_CALC) begin
			if (step_q == 4'd15) begin
				pg_q <= pg_new;
				ag_q <= asum[16] ? 16'hFFFF : asum[15:0];
				res_q.slot_index <= 6'(slot_q);
				res_q.last <= (slot_q == cnt_m1_q);
				step_q <= 4'd0;
			end else begin
				step_q <= step_q + 4'd1;
			end
			if (step_q != 4'd15 && step_q != 4'd0) begin
				case (pstep_q)
					4'd0: vx_q <= lerp_p[15:0];
					4'd1: vz_q <= lerp_p[15:0];
					4'd2: begin
						if (cfg.gravity == '0)
							vy_q <= lerp_p[15:0];
						else if (gsum > 30'sd32767)
							vy_q <= 16'h7FFF;
						else if (gsum < -30'sd32768)
							vy_q <= 16'h8000;
						else
							vy_q <= gsum[15:0];
					end
					4'd3: px_q <= sat_add24(px_q, prod_q);
					4'd4: py_q <= sat_add24(py_q, prod_q);
					4'd5: pz_q <= sat_add24(pz_q, prod_q);
					4'd6: res_q.color_r <= lerp_p[15:0];
					4'd7: res_q.color_g <= lerp_p[15:0];
					4'd8: res_q.color_b <= lerp_p[15:0];
					4'd9: res_q.color_a <= lerp_p[15:0];
					4'd10: res_q.size <= lerp_p[15:0];
					default: ;
				endcase
			end
		end else if (state_q == ST_WRITE) begin
			res_q.pos_x <= px_q; res_q.pos_y <= py_q; res_q.pos_z <= pz_q;
			res_q.age <= ag_q;
		end else if (state_q == ST_OUT) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			slot_q <= '0;
			cnt_m1_q <= '0;
			ring_q <= '0;
			timer_q <= '0;
			lfsr_q <= LFSR_SEED;
			dt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (MW+1)'(MAX_PARTICLES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_ch.valid) begin
						dt_q <= in_ch.delta_time;
						cnt_m1_q <= MW'(cnt_c - 7'd1);
						slot_q <= '0;
						if (tsat >= cfg.timing[31:16]) begin
							timer_q <= '0;
							state_q <= ST_SPAWN;
						end else begin
							timer_q <= tsat;
							state_q <= ST_READ;
						end
					end
				end
				ST_SPAWN: begin
					lfsr_q <= lfsr_n;
					ring_q <= (7'(ring_use) + 7'd1 >= cnt_c) ? '0 : MW'(ring_use + 1'b1);
					state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_CALC;
				ST_CALC: if (step_q == 4'd11) state_q <= ST_WRITE;
				ST_WRITE: if (!out_v_q || out_ch.ready) state_q <= ST_OUT;
				ST_OUT: begin
					out_v_q <= 1'b1;
					if (slot_q == cnt_m1_q) begin
						state_q <= ST_IDLE;
					end else begin
						slot_q <= slot_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> out_v_q)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ch.ready) |=> (out_v_q && $stable(out_q)))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (slot_q == '0 || slot_q == cnt_m1_q))
		else $error("slot walk incomplete");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> (slot_q <= cnt_m1_q))
		else $error("slot beyond count");
endmodule
